// ===== rtl/core/rgb_to_hsv_converter_core_assert.svh =====
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define RTH_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rgb_to_hsv check failed");

// Check that a condition in one cycle implies another in the next cycle.
`define RTH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsv sequence check failed");

`endif

// ===== rtl/core/rth_pkg.sv =====
`timescale 1ns / 1ps

package rth_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
    // Hue term 60 * 2^F * diff / delta never exceeds 60 * 2^F.
    localparam int HUE_QUO_BITS  = 6 + HUE_FRAC_BITS;
    localparam int DIV_STEPS     = (CHANNEL_BITS > HUE_QUO_BITS) ? CHANNEL_BITS : HUE_QUO_BITS;
    localparam int NUM_BITS      = CHANNEL_BITS + DIV_STEPS;

    localparam logic [CHANNEL_BITS-1:0] CHANNEL_MAX = '1;
    localparam logic [HUE_QUO_BITS-1:0] HUE_SCALE   = HUE_QUO_BITS'(60 * (1 << HUE_FRAC_BITS));
    localparam logic [HUE_BITS-1:0]     HUE_120     = HUE_BITS'(120 * (1 << HUE_FRAC_BITS));
    localparam logic [HUE_BITS-1:0]     HUE_240     = HUE_BITS'(240 * (1 << HUE_FRAC_BITS));
    localparam logic [HUE_BITS-1:0]     HUE_360     = HUE_BITS'(360 * (1 << HUE_FRAC_BITS));

    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] value;
        logic                    hue_undefined;
    } hsv_t;

    // Working data handed from one divider cell to the next.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] sat_rem;
        logic [DIV_STEPS-1:0]    sat_low;
        logic [DIV_STEPS-1:0]    sat_quo;
        logic [CHANNEL_BITS-1:0] hue_rem;
        logic [DIV_STEPS-1:0]    hue_low;
        logic [DIV_STEPS-1:0]    hue_quo;
        logic [CHANNEL_BITS-1:0] delta;
        logic [CHANNEL_BITS-1:0] value;
        logic                    hue_neg;
        logic                    undefined;
        sector_t                 sector;
    } cell_data_t;

endpackage

// ===== rtl/core/rth_front.sv =====
`timescale 1ns / 1ps

module rth_front
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_stall,
    input  pixel_t     up_data,
    output logic       dn_valid,
    input  logic       dn_stall,
    output cell_data_t dn_data
);

    logic                    valid_reg;
    cell_data_t              data_reg;
    cell_data_t              data_next;
    logic [CHANNEL_BITS-1:0] hi;
    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] opa;
    logic [CHANNEL_BITS-1:0] opc;
    logic [CHANNEL_BITS-1:0] mag;
    logic                    neg;
    sector_t                 sector;
    logic [NUM_BITS-1:0]     sat_num;
    logic [NUM_BITS-1:0]     hue_num;

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        hi = (up_data.red > up_data.green) ? up_data.red : up_data.green;
        hi = (hi > up_data.blue) ? hi : up_data.blue;
        lo = (up_data.red < up_data.green) ? up_data.red : up_data.green;
        lo = (lo < up_data.blue) ? lo : up_data.blue;
        delta = hi - lo;

        // red wins ties over green, green over blue
        if (up_data.red >= hi)
        begin
            sector = SECTOR_RED;
            opa    = up_data.green;
            opc    = up_data.blue;
        end
        else if (up_data.green >= hi)
        begin
            sector = SECTOR_GREEN;
            opa    = up_data.blue;
            opc    = up_data.red;
        end
        else
        begin
            sector = SECTOR_BLUE;
            opa    = up_data.red;
            opc    = up_data.green;
        end
        neg = opa < opc;
        mag = neg ? (opc - opa) : (opa - opc);

        sat_num = NUM_BITS'(delta) * NUM_BITS'(CHANNEL_MAX);
        hue_num = NUM_BITS'(mag) * NUM_BITS'(HUE_SCALE);

        data_next.sat_rem   = sat_num[NUM_BITS-1 -: CHANNEL_BITS];
        data_next.sat_low   = sat_num[DIV_STEPS-1:0];
        data_next.sat_quo   = '0;
        data_next.hue_rem   = hue_num[NUM_BITS-1 -: CHANNEL_BITS];
        data_next.hue_low   = hue_num[DIV_STEPS-1:0];
        data_next.hue_quo   = '0;
        data_next.delta     = delta;
        data_next.value     = hi;
        data_next.hue_neg   = neg;
        data_next.undefined = (delta == '0);
        data_next.sector    = sector;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/rth_cell.sv =====
`timescale 1ns / 1ps

module rth_cell
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_stall,
    input  cell_data_t up_data,
    output logic       dn_valid,
    input  logic       dn_stall,
    output cell_data_t dn_data
);

    logic                    valid_reg;
    cell_data_t              data_reg;
    cell_data_t              data_next;
    logic [CHANNEL_BITS:0]   sat_cat;
    logic [CHANNEL_BITS:0]   hue_cat;
    logic                    sat_ge;
    logic                    hue_ge;
    logic [CHANNEL_BITS:0]   sat_diff;
    logic [CHANNEL_BITS:0]   hue_diff;

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // One restoring division step on each lane: saturation over value, hue over delta.
    always_comb
    begin
        data_next = up_data;

        sat_cat  = {up_data.sat_rem, up_data.sat_low[DIV_STEPS-1]};
        sat_ge   = sat_cat >= {1'b0, up_data.value};
        sat_diff = sat_cat - {1'b0, up_data.value};
        data_next.sat_rem = sat_ge ? sat_diff[CHANNEL_BITS-1:0] : sat_cat[CHANNEL_BITS-1:0];
        data_next.sat_low = up_data.sat_low << 1;
        data_next.sat_quo = {up_data.sat_quo[DIV_STEPS-2:0], sat_ge};

        hue_cat  = {up_data.hue_rem, up_data.hue_low[DIV_STEPS-1]};
        hue_ge   = hue_cat >= {1'b0, up_data.delta};
        hue_diff = hue_cat - {1'b0, up_data.delta};
        data_next.hue_rem = hue_ge ? hue_diff[CHANNEL_BITS-1:0] : hue_cat[CHANNEL_BITS-1:0];
        data_next.hue_low = up_data.hue_low << 1;
        data_next.hue_quo = {up_data.hue_quo[DIV_STEPS-2:0], hue_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/rth_tail.sv =====
`timescale 1ns / 1ps

module rth_tail
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_stall,
    input  cell_data_t up_data,
    output logic       dn_valid,
    input  logic       dn_stall,
    output hsv_t       dn_data
);

    logic                    valid_reg;
    hsv_t                    data_reg;
    hsv_t                    data_next;
    logic [HUE_BITS-1:0]     quo;
    logic [HUE_BITS-1:0]     base;

    assign up_stall = valid_reg && dn_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        quo = HUE_BITS'(up_data.hue_quo[HUE_QUO_BITS-1:0]);

        case (up_data.sector)
            SECTOR_RED:   base = '0;
            SECTOR_GREEN: base = HUE_120;
            SECTOR_BLUE:  base = HUE_240;
            default:      base = '0;
        endcase

        // wrap a negative red-sector hue; a zero term stays at zero
        if (up_data.hue_neg && (up_data.sector == SECTOR_RED) && (quo != '0))
        begin
            base = HUE_360;
        end

        if (up_data.undefined)
        begin
            data_next.hue = '0;
        end
        else if (up_data.hue_neg)
        begin
            data_next.hue = base - quo;
        end
        else
        begin
            data_next.hue = base + quo;
        end

        data_next.saturation    = (up_data.value == '0) ? '0
                                                        : up_data.sat_quo[CHANNEL_BITS-1:0];
        data_next.value         = up_data.value;
        data_next.hue_undefined = up_data.undefined;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/rgb_to_hsv_converter_core.sv =====
`timescale 1ns / 1ps
// RGB to HSV converter, one pixel per request.
//
// Input channel: pixel_valid / pixel_stall carry a pixel_t request (red, green,
// blue, unsigned). A request is taken on a rising edge with pixel_valid high and
// pixel_stall low. Output channel: hsv_valid / hsv_stall carry an hsv_t request
// (hue in degrees with six fraction bits, saturation, value, hue_undefined).
//
// Throughput: one pixel per clock while pixel_stall is low. Structure: one front
// cell that finds max, min, sector and the two dividends, a chain of DIV_STEPS
// divider cells that each retire one quotient bit for the saturation and the
// hue lanes, and one tail cell that adds the sector offset, wraps negative hue
// and drives the output register.
//
// Each cell holds its own valid bit, so a bubble closes up: while the receiver
// stalls, new pixels keep entering until the chain is full. When every cell
// holds a request, pixel_stall follows hsv_stall. Reset clears all valid bits;
// no request is in flight afterwards. Payload registers are not reset.
module rgb_to_hsv_converter_core
    import rth_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   hsv_valid,
    input  logic   hsv_stall,
    output hsv_t   hsv
);

    // chain links: index 0 is the front cell output, DIV_STEPS the last divider
    logic       link_valid [DIV_STEPS+1];
    logic       link_stall [DIV_STEPS+1];
    cell_data_t link_data  [DIV_STEPS+1];

    rth_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_stall (pixel_stall),
        .up_data  (pixel),
        .dn_valid (link_valid[0]),
        .dn_stall (link_stall[0]),
        .dn_data  (link_data[0])
    );

    // one cell per quotient bit, most significant first
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        rth_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_stall (link_stall[i]),
            .up_data  (link_data[i]),
            .dn_valid (link_valid[i+1]),
            .dn_stall (link_stall[i+1]),
            .dn_data  (link_data[i+1])
        );
    end

    rth_tail u_tail (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[DIV_STEPS]),
        .up_stall (link_stall[DIV_STEPS]),
        .up_data  (link_data[DIV_STEPS]),
        .dn_valid (hsv_valid),
        .dn_stall (hsv_stall),
        .dn_data  (hsv)
    );

endmodule

// ===== rtl/core/rth_checker.sv =====
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_core_assert.svh"

module rth_checker
    import rth_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pixel_valid,
    input logic   pixel_stall,
    input pixel_t pixel,
    input logic   hsv_valid,
    input logic   hsv_stall,
    input hsv_t   hsv
);

    // a stalled result holds until taken
    `RTH_ASSERT_NEXT(a_hold_stalled, hsv_valid && hsv_stall, hsv_valid && $stable(hsv))

    // hue stays below 360 degrees
    `RTH_ASSERT_HOLDS(a_hue_range, !hsv_valid || (hsv.hue < HUE_360))

    // an undefined hue is reported as zero
    `RTH_ASSERT_HOLDS(a_undef_zero, !hsv_valid || !hsv.hue_undefined || (hsv.hue == '0))

    // black has no saturation and no hue
    `RTH_ASSERT_HOLDS(a_black, !hsv_valid || (hsv.value != '0) || ((hsv.saturation == '0) && hsv.hue_undefined))

endmodule

bind rgb_to_hsv_converter_core rth_checker u_rth_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rth_pkg::*;

    localparam int RANDOM_PIXELS = 1150;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int DIRECTED_ROWS = 24;

    // One row of stimulus: the pixel, and a typed-in result where one is given.
    typedef struct packed {
        pixel_t px;
        logic   typed;
        hsv_t   want;
    } stim_row_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   pixel_valid = 1'b0;
    logic   pixel_stall;
    pixel_t pixel       = '0;
    logic   hsv_valid;
    logic   hsv_stall   = 1'b0;
    hsv_t   hsv;

    stim_row_t pixel_requests [$];
    hsv_t      hsv_expected_q [$];
    stim_row_t next_row;
    logic      cur_typed = 1'b0;
    hsv_t      cur_want  = '0;
    int        next_item  = 0;
    int        items_sent = 0;
    int        send_gap   = 0;
    int        send_calm  = 0;
    int        stall_hold = 0;
    int        stall_calm = 0;
    int        idle_cycles = 0;
    int        mismatches  = 0;

    // Directed rows: extremes, each sector, ties for the maximum, equal channels
    // and negative hue terms. Rows with typed = 0 go through the predictor.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        {8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     8'd0,   8'd0,   1'b1},
        {8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     8'd0,   8'd255, 1'b1},
        {8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     8'd0,   8'd128, 1'b1},
        {8'd1,   8'd1,   8'd1,   1'b1, 15'd0,     8'd0,   8'd1,   1'b1},
        {8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     8'd255, 8'd255, 1'b0},
        {8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  8'd255, 8'd255, 1'b0},
        {8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 8'd255, 8'd255, 1'b0},
        {8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  8'd255, 8'd255, 1'b0},
        {8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 8'd255, 8'd255, 1'b0},
        {8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 8'd255, 8'd255, 1'b0},
        {8'd1,   8'd0,   8'd0,   1'b0, 32'd0},
        {8'd0,   8'd0,   8'd1,   1'b0, 32'd0},
        {8'd255, 8'd254, 8'd255, 1'b0, 32'd0},
        {8'd255, 8'd0,   8'd1,   1'b0, 32'd0},
        {8'd254, 8'd255, 8'd255, 1'b0, 32'd0},
        {8'd255, 8'd255, 8'd254, 1'b0, 32'd0},
        {8'd1,   8'd1,   8'd0,   1'b0, 32'd0},
        {8'd0,   8'd1,   8'd1,   1'b0, 32'd0},
        {8'd1,   8'd0,   8'd1,   1'b0, 32'd0},
        {8'd200, 8'd100, 8'd50,  1'b0, 32'd0},
        {8'd10,  8'd200, 8'd30,  1'b0, 32'd0},
        {8'd30,  8'd20,  8'd240, 1'b0, 32'd0},
        {8'd255, 8'd1,   8'd0,   1'b0, 32'd0},
        {8'd170, 8'd85,  8'd255, 1'b0, 32'd0}
    };

    rgb_to_hsv_converter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hsv         (hsv)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hsv_t rgb_to_hsv_predict(pixel_t p);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   delta;
        int   offset;
        int   diff;
        int   h;
        int   hue_one;
        int   full;
        hsv_t res;
        hue_one = 1 << HUE_FRAC_BITS;
        full    = (1 << CHANNEL_BITS) - 1;
        r = int'(p.red);
        g = int'(p.green);
        b = int'(p.blue);
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        delta = hi - lo;
        res.value      = hi[CHANNEL_BITS-1:0];
        res.saturation = (hi > 0) ? CHANNEL_BITS'((delta * full) / hi) : '0;
        if (delta == 0)
        begin
            res.hue           = '0;
            res.hue_undefined = 1'b1;
        end
        else
        begin
            if (r >= hi)
            begin
                offset = 0;
                diff   = g - b;
            end
            else if (g >= hi)
            begin
                offset = 120;
                diff   = b - r;
            end
            else
            begin
                offset = 240;
                diff   = r - g;
            end
            // Signed division truncates toward zero.
            h = offset * hue_one + (60 * hue_one * diff) / delta;
            if (h < 0)
                h += 360 * hue_one;
            res.hue           = HUE_BITS'(h);
            res.hue_undefined = 1'b0;
        end
        return res;
    endfunction

    // Idle length: mostly none or short, a few long, and now and then a calm stretch.
    function automatic int pick_idle(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 6)
            return $urandom_range(15, 60);
        if (roll < 50)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] edge_level();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return CHANNEL_BITS'(1);
            2: return CHANNEL_MAX - 1'b1;
            default: return CHANNEL_MAX;
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        int     roll;
        int     k;
        int     v;
        int     w;
        pixel_t p;
        roll = $urandom_range(0, 99);
        p.red   = CHANNEL_BITS'($urandom_range(0, 255));
        p.green = CHANNEL_BITS'($urandom_range(0, 255));
        p.blue  = CHANNEL_BITS'($urandom_range(0, 255));
        if (roll < 55)
            return p;
        if (roll < 65)
        begin
            // grey: all channels equal
            v = $urandom_range(0, 255);
            p.red   = CHANNEL_BITS'(v);
            p.green = CHANNEL_BITS'(v);
            p.blue  = CHANNEL_BITS'(v);
        end
        else if (roll < 75)
        begin
            // two channels tie for the maximum
            k = $urandom_range(0, 2);
            v = $urandom_range(0, 255);
            w = $urandom_range(0, v);
            p.red   = CHANNEL_BITS'((k == 0) ? w : v);
            p.green = CHANNEL_BITS'((k == 1) ? w : v);
            p.blue  = CHANNEL_BITS'((k == 2) ? w : v);
        end
        else if (roll < 85)
        begin
            // tiny delta, large hue steps
            v = $urandom_range(0, 253);
            p.red   = CHANNEL_BITS'(v + int'($urandom_range(0, 2)));
            p.green = CHANNEL_BITS'(v + int'($urandom_range(0, 2)));
            p.blue  = CHANNEL_BITS'(v + int'($urandom_range(0, 2)));
        end
        else if (roll < 95)
        begin
            p.red   = edge_level();
            p.green = edge_level();
            p.blue  = edge_level();
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: p.red = CHANNEL_MAX;
                1: p.green = CHANNEL_MAX;
                default: p.blue = CHANNEL_MAX;
            endcase
        end
        return p;
    endfunction

    task automatic report_field(string field, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic cur_check(hsv_t want);
        report_field("hue", int'(want.hue), int'(hsv.hue));
        report_field("saturation", int'(want.saturation), int'(hsv.saturation));
        report_field("value", int'(want.value), int'(hsv.value));
        report_field("hue_undefined", int'(want.hue_undefined), int'(hsv.hue_undefined));
    endtask

    // Pixel side: record each accepted request, then load the next one after its gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                hsv_expected_q.push_back(cur_typed ? cur_want : rgb_to_hsv_predict(pixel));
                items_sent++;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pixel_valid <= 1'b0;
                end
                else if (next_item < pixel_requests.size())
                begin
                    next_row = pixel_requests[next_item];
                    next_item++;
                    pixel       <= next_row.px;
                    pixel_valid <= 1'b1;
                    cur_typed = next_row.typed;
                    cur_want  = next_row.want;
                    send_gap  = pick_idle(send_calm);
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: alternate runs of readiness and stalls of random length.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_hold > 0)
            begin
                stall_hold--;
            end
            else
            begin
                hsv_stall  <= !hsv_stall;
                stall_hold = hsv_stall ? $urandom_range(1, 20) : pick_idle(stall_calm);
            end
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (hsv_expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual hue %0d sat %0d val %0d",
                         $time, hsv.hue, hsv.saturation, hsv.value);
            end
            else
            begin
                cur_check(hsv_expected_q.pop_front());
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t row;
        foreach (directed_rows[i])
            pixel_requests.push_back(directed_rows[i]);
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            row       = '0;
            row.px    = random_pixel();
            row.typed = 1'b0;
            pixel_requests.push_back(row);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (items_sent < pixel_requests.size() || hsv_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && hsv_expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rth_pkg.sv
rtl/core/rth_front.sv
rtl/core/rth_cell.sv
rtl/core/rth_tail.sv
rtl/core/rgb_to_hsv_converter_core.sv
rtl/core/rth_checker.sv
bench/testbench.sv
